// ----- hw/rtl/atr_pkg.sv -----
// ----------------------------------------------------------------------------
// atr_pkg: shared types for the smart card ATR parser
// Byte kinds, convention and status codes, and the transfer payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package atr_pkg;

  // classification of one ATR byte
  typedef enum logic [3:0] {
    KIND_TS    = 4'd0,
    KIND_T0    = 4'd1,
    KIND_TA    = 4'd2,
    KIND_TB    = 4'd3,
    KIND_TC    = 4'd4,
    KIND_TD    = 4'd5,
    KIND_HIST  = 4'd6,
    KIND_TCK   = 4'd7,
    KIND_EXTRA = 4'd8
  } byte_kind_e;

  // coding convention from TS
  typedef enum logic [1:0] {
    CONV_DIRECT  = 2'd0,
    CONV_INVERSE = 2'd1,
    CONV_UNKNOWN = 2'd2
  } conv_e;

  // status reported with each result
  typedef enum logic [2:0] {
    STAT_BUSY      = 3'd0,
    STAT_TOO_SHORT = 3'd1,
    STAT_NO_TCK    = 3'd2,
    STAT_TCK_GOOD  = 3'd3,
    STAT_TCK_BAD   = 3'd4
  } status_e;

  // parser phase, one-hot
  typedef enum logic [5:0] {
    PH_TS   = 6'b000001,
    PH_T0   = 6'b000010,
    PH_IF   = 6'b000100,
    PH_HIST = 6'b001000,
    PH_TCK  = 6'b010000,
    PH_XTRA = 6'b100000
  } phase_e;

  localparam logic [7:0] TS_DIRECT   = 8'h3B;
  localparam logic [7:0] TS_INVERSE  = 8'h3F;
  localparam logic [7:0] ASCII_FIRST = 8'd32;
  localparam logic [7:0] ASCII_LAST  = 8'd126;
  localparam logic [7:0] ASCII_DOT   = 8'd46;
  localparam logic [4:0] LEVEL_MAX   = 5'd31;

  // input transfer payload
  typedef struct packed {
    logic [7:0] atr_byte;
    logic       last_byte;
  } atr_in_t;

  // output transfer payload
  typedef struct packed {
    logic [3:0] byte_kind;
    logic [4:0] iface_level;
    logic [3:0] protocol_type;
    logic [3:0] next_mask;
    logic [3:0] hist_count;
    logic [7:0] ascii_char;
    logic [1:0] convention;
    logic [2:0] final_status;
    logic       end_flag;
  } atr_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/smart_card_atr_parser.sv -----
// ----------------------------------------------------------------------------
// smart_card_atr_parser: ISO 7816-3 answer-to-reset byte classifier
// Classifies each ATR byte, tracks the interface chain and historical bytes,
// and checks TCK against the XOR of T0 through TCK on the last byte.
// ----------------------------------------------------------------------------
// path: a byte taken into the input register has its result loaded into the
//   result register, which drives out_valid_o, once out_stall_i lets it load
// throughput: one byte per cycle unless out_stall_i stalls; the parser state
//   update is one pass of logic between the input and result registers
// reset: rst_ni clears the valid bits and returns the parser to expect TS;
//   the last byte of an ATR also returns the parser to that state
`default_nettype none

module smart_card_atr_parser #(
  parameter int MAX_ATR_BYTES = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire atr_pkg::atr_in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output atr_pkg::atr_out_t    out_data_o
);

  localparam int CntW = $clog2(MAX_ATR_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ATR_BYTES);
  localparam logic [CntW-1:0] CntMin = CntW'(2);

  // input register
  logic             in1_valid_q;
  atr_pkg::atr_in_t in1_data_q;

  // result register
  logic              out_valid_q;
  atr_pkg::atr_out_t out_data_q, out_data_d;

  // parser state
  atr_pkg::phase_e phase_q, phase_d;
  logic [3:0]      pmask_q, pmask_d;
  logic [4:0]      level_q, level_d;
  logic [3:0]      hist_left_q, hist_left_d;
  logic [3:0]      hist_total_q, hist_total_d;
  logic [7:0]      xor_q, xor_d;
  logic [CntW-1:0] count_q, count_d;
  atr_pkg::conv_e  conv_q, conv_d;
  logic            tck_seen_q, tck_seen_d;

  logic s2_ready, s1_fire, in_fire;

  // handshake
  assign s2_ready    = !out_valid_q || !out_stall_i;
  assign s1_fire     = in1_valid_q && s2_ready;
  assign in_stall_o  = in1_valid_q && !s2_ready;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // classify the held byte and update the parser state
  always_comb begin
    logic [7:0]         b;
    logic [3:0]         hi_nib;
    logic [3:0]         lo_nib;
    atr_pkg::byte_kind_e kind;
    atr_pkg::phase_e    after_if;
    atr_pkg::status_e   status;
    b        = in1_data_q.atr_byte;
    hi_nib   = b[7:4];
    lo_nib   = b[3:0];
    kind     = atr_pkg::KIND_EXTRA;
    after_if = (hist_left_q != 4'd0) ? atr_pkg::PH_HIST : atr_pkg::PH_TCK;
    status   = atr_pkg::STAT_BUSY;

    phase_d      = phase_q;
    pmask_d      = pmask_q;
    level_d      = level_q;
    hist_left_d  = hist_left_q;
    hist_total_d = hist_total_q;
    xor_d        = xor_q;
    count_d      = count_q;
    conv_d       = conv_q;
    tck_seen_d   = tck_seen_q;

    out_data_d               = '0;
    out_data_d.end_flag      = in1_data_q.last_byte;

    if (count_q < CntMax) begin
      count_d = count_q + CntW'(1);
      case (phase_q)
        atr_pkg::PH_TS: begin
          kind = atr_pkg::KIND_TS;
          if (b == atr_pkg::TS_DIRECT) begin
            conv_d = atr_pkg::CONV_DIRECT;
          end else if (b == atr_pkg::TS_INVERSE) begin
            conv_d = atr_pkg::CONV_INVERSE;
          end else begin
            conv_d = atr_pkg::CONV_UNKNOWN;
          end
          phase_d = atr_pkg::PH_T0;
        end
        atr_pkg::PH_T0: begin
          kind                  = atr_pkg::KIND_T0;
          xor_d                 = b;
          out_data_d.next_mask  = hi_nib;
          out_data_d.hist_count = lo_nib;
          hist_total_d          = lo_nib;
          hist_left_d           = lo_nib;
          pmask_d               = hi_nib;
          level_d               = 5'd1;
          if (hi_nib != 4'd0) begin
            phase_d = atr_pkg::PH_IF;
          end else if (lo_nib != 4'd0) begin
            phase_d = atr_pkg::PH_HIST;
          end else begin
            phase_d = atr_pkg::PH_TCK;
          end
        end
        atr_pkg::PH_IF: begin
          xor_d                  = xor_q ^ b;
          out_data_d.iface_level = level_q;
          if (pmask_q[0]) begin
            kind    = atr_pkg::KIND_TA;
            pmask_d = {pmask_q[3:1], 1'b0};
          end else if (pmask_q[1]) begin
            kind    = atr_pkg::KIND_TB;
            pmask_d = {pmask_q[3:2], 2'b00};
          end else if (pmask_q[2]) begin
            kind    = atr_pkg::KIND_TC;
            pmask_d = {pmask_q[3], 3'b000};
          end else begin
            kind                     = atr_pkg::KIND_TD;
            out_data_d.protocol_type = lo_nib;
            out_data_d.next_mask     = hi_nib;
            pmask_d                  = hi_nib;
            if (level_q < atr_pkg::LEVEL_MAX) begin
              level_d = level_q + 5'd1;
            end
          end
          if (pmask_d == 4'd0) begin
            phase_d = after_if;
          end
        end
        atr_pkg::PH_HIST: begin
          kind                  = atr_pkg::KIND_HIST;
          xor_d                 = xor_q ^ b;
          out_data_d.hist_count = hist_total_q;
          if (b >= atr_pkg::ASCII_FIRST && b <= atr_pkg::ASCII_LAST) begin
            out_data_d.ascii_char = b;
          end else begin
            out_data_d.ascii_char = atr_pkg::ASCII_DOT;
          end
          if (hist_left_q != 4'd0) begin
            hist_left_d = hist_left_q - 4'd1;
          end
          if (hist_left_d == 4'd0) begin
            phase_d = atr_pkg::PH_TCK;
          end
        end
        atr_pkg::PH_TCK: begin
          kind       = atr_pkg::KIND_TCK;
          xor_d      = xor_q ^ b;
          tck_seen_d = 1'b1;
          phase_d    = atr_pkg::PH_XTRA;
        end
        default: begin
          kind = atr_pkg::KIND_EXTRA;
        end
      endcase
    end

    // final status on the last byte
    if (in1_data_q.last_byte) begin
      if (count_d < CntMin) begin
        status = atr_pkg::STAT_TOO_SHORT;
      end else if (!tck_seen_d) begin
        status = atr_pkg::STAT_NO_TCK;
      end else if (xor_d == 8'd0) begin
        status = atr_pkg::STAT_TCK_GOOD;
      end else begin
        status = atr_pkg::STAT_TCK_BAD;
      end
    end

    out_data_d.byte_kind    = kind;
    out_data_d.convention   = conv_d;
    out_data_d.final_status = status;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in1_data_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= in1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q <= out_data_d;
    end
  end

  // parser state, back to reset values after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= atr_pkg::PH_TS;
      pmask_q      <= '0;
      level_q      <= '0;
      hist_left_q  <= '0;
      hist_total_q <= '0;
      xor_q        <= '0;
      count_q      <= '0;
      conv_q       <= atr_pkg::CONV_UNKNOWN;
      tck_seen_q   <= 1'b0;
    end else if (s1_fire) begin
      if (in1_data_q.last_byte) begin
        phase_q      <= atr_pkg::PH_TS;
        pmask_q      <= '0;
        level_q      <= '0;
        hist_left_q  <= '0;
        hist_total_q <= '0;
        xor_q        <= '0;
        count_q      <= '0;
        conv_q       <= atr_pkg::CONV_UNKNOWN;
        tck_seen_q   <= 1'b0;
      end else begin
        phase_q      <= phase_d;
        pmask_q      <= pmask_d;
        level_q      <= level_d;
        hist_left_q  <= hist_left_d;
        hist_total_q <= hist_total_d;
        xor_q        <= xor_d;
        count_q      <= count_d;
        conv_q       <= conv_d;
        tck_seen_q   <= tck_seen_d;
      end
    end
  end

  // checks
  a_status_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.final_status != atr_pkg::STAT_BUSY) == out_data_o.end_flag))
    else $error("final status does not match end flag");

  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && in1_data_q.last_byte) |=> (phase_q == atr_pkg::PH_TS && count_q == '0))
    else $error("parser not back at TS after last byte");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("byte count beyond limit");

  a_proto_only_td: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.byte_kind != atr_pkg::KIND_TD) |->
      out_data_o.protocol_type == 4'd0)
    else $error("protocol type on a non-TD byte");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in1_valid_q && out_valid_q))
    else $error("input stalled with room downstream");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for smart_card_atr_parser
// Feeds directed and random ATR byte streams through the valid/stall input,
// predicts every result with a behavioral copy of the parser kept in a
// scoreboard class, and compares each output transfer field by field.
// ----------------------------------------------------------------------------

// behavioral parser plus queue of results still owed by the block
class atr_scoreboard;
  localparam int BYTES_MAX = 32;

  atr_pkg::atr_out_t expected_results[$];
  int                failures;

  atr_pkg::phase_e step;
  bit [3:0]        mask_left;
  bit [4:0]        level;
  bit [3:0]        hist_remaining;
  bit [3:0]        hist_len;
  bit [7:0]        parity;
  bit [5:0]        taken;
  atr_pkg::conv_e  conv;
  bit              tck_done;

  function new();
    failures = 0;
    clear();
  endfunction

  function void clear();
    step           = atr_pkg::PH_TS;
    mask_left      = '0;
    level          = '0;
    hist_remaining = '0;
    hist_len       = '0;
    parity         = '0;
    taken          = '0;
    conv           = atr_pkg::CONV_UNKNOWN;
    tck_done       = 1'b0;
  endfunction

  // phase once the interface chain is done
  function atr_pkg::phase_e past_iface();
    return (hist_remaining != 0) ? atr_pkg::PH_HIST : atr_pkg::PH_TCK;
  endfunction

  // next parser state and the result for one ATR byte
  function atr_pkg::atr_out_t classify_byte(atr_pkg::atr_in_t item);
    atr_pkg::atr_out_t r;
    logic [7:0]        b;
    b = item.atr_byte;
    r = '0;
    r.byte_kind = atr_pkg::KIND_EXTRA;
    if (taken < BYTES_MAX) begin
      taken++;
      case (step)
        atr_pkg::PH_TS: begin
          r.byte_kind = atr_pkg::KIND_TS;
          conv = (b == atr_pkg::TS_DIRECT) ? atr_pkg::CONV_DIRECT :
                 (b == atr_pkg::TS_INVERSE) ? atr_pkg::CONV_INVERSE : atr_pkg::CONV_UNKNOWN;
          step = atr_pkg::PH_T0;
        end
        atr_pkg::PH_T0: begin
          r.byte_kind    = atr_pkg::KIND_T0;
          parity         = b;
          r.next_mask    = b[7:4];
          hist_len       = b[3:0];
          hist_remaining = b[3:0];
          r.hist_count   = b[3:0];
          mask_left      = b[7:4];
          level          = 5'd1;
          step = (mask_left != 0) ? atr_pkg::PH_IF : past_iface();
        end
        atr_pkg::PH_IF: begin
          parity ^= b;
          r.iface_level = level;
          if (mask_left[0]) begin
            r.byte_kind  = atr_pkg::KIND_TA;
            mask_left[0] = 1'b0;
          end else if (mask_left[1]) begin
            r.byte_kind  = atr_pkg::KIND_TB;
            mask_left[1] = 1'b0;
          end else if (mask_left[2]) begin
            r.byte_kind  = atr_pkg::KIND_TC;
            mask_left[2] = 1'b0;
          end else begin
            r.byte_kind     = atr_pkg::KIND_TD;
            r.protocol_type = b[3:0];
            r.next_mask     = b[7:4];
            mask_left       = b[7:4];
            if (level < atr_pkg::LEVEL_MAX) level++;
          end
          if (mask_left == 0) step = past_iface();
        end
        atr_pkg::PH_HIST: begin
          r.byte_kind  = atr_pkg::KIND_HIST;
          parity      ^= b;
          r.hist_count = hist_len;
          r.ascii_char = (b >= atr_pkg::ASCII_FIRST && b <= atr_pkg::ASCII_LAST) ?
                         b : atr_pkg::ASCII_DOT;
          if (hist_remaining != 0) hist_remaining--;
          if (hist_remaining == 0) step = atr_pkg::PH_TCK;
        end
        atr_pkg::PH_TCK: begin
          r.byte_kind = atr_pkg::KIND_TCK;
          parity     ^= b;
          tck_done    = 1'b1;
          step        = atr_pkg::PH_XTRA;
        end
        default: r.byte_kind = atr_pkg::KIND_EXTRA;
      endcase
    end
    r.convention = conv;
    r.end_flag   = item.last_byte;
    r.final_status = atr_pkg::STAT_BUSY;
    if (item.last_byte) begin
      if (taken < 2)          r.final_status = atr_pkg::STAT_TOO_SHORT;
      else if (!tck_done)     r.final_status = atr_pkg::STAT_NO_TCK;
      else if (parity == 0)   r.final_status = atr_pkg::STAT_TCK_GOOD;
      else                    r.final_status = atr_pkg::STAT_TCK_BAD;
      clear();
    end
    return r;
  endfunction

  // an input transfer was taken by the block
  function void note_input(atr_pkg::atr_in_t item);
    expected_results.push_back(classify_byte(item));
  endfunction

  function void report(string what, atr_pkg::atr_out_t want, atr_pkg::atr_out_t got);
    if (failures < 10)
      $display("%s: kind %0d/%0d lvl %0d/%0d proto %0d/%0d mask %0d/%0d hist %0d/%0d",
               what, want.byte_kind, got.byte_kind, want.iface_level, got.iface_level,
               want.protocol_type, got.protocol_type, want.next_mask, got.next_mask,
               want.hist_count, got.hist_count);
    if (failures < 10)
      $display("  char %0d/%0d conv %0d/%0d status %0d/%0d end %0d/%0d (expected/actual)",
               want.ascii_char, got.ascii_char, want.convention, got.convention,
               want.final_status, got.final_status, want.end_flag, got.end_flag);
    failures++;
  endfunction

  // an output transfer was taken from the block
  function void check_result(atr_pkg::atr_out_t got);
    atr_pkg::atr_out_t want;
    bit                bad;
    if (expected_results.size() == 0) begin
      report("result with nothing expected", '0, got);
      return;
    end
    want = expected_results.pop_front();
    bad = (got.byte_kind     !== want.byte_kind)     ||
          (got.iface_level   !== want.iface_level)   ||
          (got.protocol_type !== want.protocol_type) ||
          (got.next_mask     !== want.next_mask)     ||
          (got.hist_count    !== want.hist_count)    ||
          (got.ascii_char    !== want.ascii_char)    ||
          (got.convention    !== want.convention)    ||
          (got.final_status  !== want.final_status)  ||
          (got.end_flag      !== want.end_flag);
    if (bad) report("result mismatch", want, got);
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 600;
  localparam int HOLD_CYCLES = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  atr_pkg::atr_in_t  in_data = '0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall = 1'b0;
  atr_pkg::atr_out_t out_data;

  atr_scoreboard sb;
  bit [7:0]      atr_seq[$];
  int            bytes_sent = 0;
  int            cycles = 0;
  bit            tx_calm = 1'b0;
  bit            hold_rx = 1'b0;

  smart_card_atr_parser #(
    .MAX_ATR_BYTES(32)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // offer one byte and return once its transfer is certain at the next edge
  task automatic send_byte(input bit [7:0] b, input bit last);
    atr_pkg::atr_in_t item;
    int               gap;
    item.atr_byte  = b;
    item.last_byte = last;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(posedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(posedge clk_i);
    end
    @(posedge clk_i);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk_i); while (in_stall);
    sb.note_input(item);
    bytes_sent++;
  endtask

  // send the bytes in atr_seq as one ATR, flagging the final one
  task automatic send_atr();
    for (int i = 0; i < atr_seq.size(); i++)
      send_byte(atr_seq[i], i == atr_seq.size() - 1);
  endtask

  // random ATR: mostly well formed, sometimes truncated, overlong, missing or bad TCK
  function automatic void build_atr();
    bit [7:0] sum;
    bit [7:0] td;
    bit [7:0] v;
    bit [3:0] mask;
    bit [3:0] hist_n;
    int       depth;
    int       depth_max;
    int       r;
    int       cut;
    atr_seq.delete();
    r = $urandom_range(0, 9);
    if (r == 0)     atr_seq.push_back(8'($urandom_range(0, 255)));
    else if (r < 5) atr_seq.push_back(atr_pkg::TS_DIRECT);
    else            atr_seq.push_back(atr_pkg::TS_INVERSE);
    mask   = 4'($urandom_range(0, 15));
    hist_n = 4'($urandom_range(0, 15));
    sum    = {mask, hist_n};
    atr_seq.push_back(sum);
    depth_max = ($urandom_range(0, 24) == 0) ? 40 : $urandom_range(0, 4);
    depth     = 0;
    // interface chain
    while (mask != 0) begin
      for (int j = 0; j < 3; j++) begin
        if (mask[j]) begin
          v = 8'($urandom_range(0, 255));
          atr_seq.push_back(v);
          sum ^= v;
        end
      end
      if (mask[3]) begin
        depth++;
        td    = 8'($urandom_range(0, 255));
        td[7] = (depth_max > 4) ? (depth < depth_max) : (td[7] && depth < depth_max);
        atr_seq.push_back(td);
        sum ^= td;
        mask = td[7:4];
      end else begin
        mask = '0;
      end
    end
    // historical bytes
    repeat (hist_n) begin
      v = 8'($urandom_range(0, 255));
      atr_seq.push_back(v);
      sum ^= v;
    end
    // check byte, sometimes wrong or missing
    r = $urandom_range(0, 9);
    if (r == 1)      atr_seq.push_back(sum ^ 8'($urandom_range(1, 255)));
    else if (r != 0) atr_seq.push_back(sum);
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) atr_seq.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, atr_seq.size());
      while (atr_seq.size() > cut) void'(atr_seq.pop_back());
    end
  endfunction

  // receiver: random stall, quiet stretches, and the long hold-off
  initial begin : rx_side
    int  stall_left;
    int  calm_left;
    bit  stall;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        stall = 1'b1;
      end else if (calm_left > 0) begin
        stall = 1'b0;
        calm_left--;
      end else begin
        if (stall_left == 0) begin
          if ($urandom_range(0, 49) == 0)      calm_left  = $urandom_range(30, 150);
          else if ($urandom_range(0, 3) == 0)  stall_left = pick_gap();
        end
        stall = (stall_left != 0);
        if (stall) stall_left--;
      end
      out_stall <= stall;
      @(negedge clk_i);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // hold the output once mid-run so the block backs up into its input
  initial begin : rx_hold
    while (bytes_sent < 200) @(negedge clk_i);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_rx = 1'b0;
  end

  // stimulus and end of run
  initial begin : tx_side
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single byte, too short
    atr_seq = '{8'h3B};
    send_atr();
    // ends on T0, no check byte
    atr_seq = '{8'h3F, 8'h00};
    send_atr();
    // unknown convention, bare T0, check byte right after
    atr_seq = '{8'h12, 8'h00, 8'h00};
    send_atr();
    // full chain TA TB TC TD, second TD with TA3, ascii edges, good TCK, extra
    atr_seq = '{8'h3B, 8'hF5, 8'h11, 8'h22, 8'h33, 8'h81, 8'h1F, 8'hAA,
                8'h1F, 8'h20, 8'h7E, 8'h7F, 8'hFF};
    begin
      bit [7:0] sum;
      sum = '0;
      for (int i = 1; i < atr_seq.size(); i++) sum ^= atr_seq[i];
      atr_seq.push_back(sum);
    end
    atr_seq.push_back(8'h00);
    send_atr();
    // bad check byte
    atr_seq = '{8'h3B, 8'h00, 8'h5A};
    send_atr();

    // random ATRs and noise
    while (bytes_sent < RANDOM_BYTES) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) == 0) begin
        atr_seq.delete();
        repeat ($urandom_range(1, 40)) atr_seq.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_atr();
      end
      send_atr();
    end
    @(posedge clk_i);
    in_valid <= 1'b0;

    // drain and settle
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    sb.failures += sb.expected_results.size();
    if (sb.failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/atr_pkg.sv
hw/rtl/smart_card_atr_parser.sv
bench/testbench.sv
